// File: rtl/cubic_bezier_forward_difference_defines.svh
// Assertion macros for the curve point generator.
`ifndef CUBIC_BEZIER_FORWARD_DIFFERENCE_DEFINES_SVH
`define CUBIC_BEZIER_FORWARD_DIFFERENCE_DEFINES_SVH

// same-cycle implication
`define CBFD_ASSERT_IMP(name, lhs, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);

// next-cycle implication
`define CBFD_ASSERT_NEXT(name, lhs, rhs, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: rtl/cbfd_pkg.sv
package cbfd_pkg;

    localparam int ACC_W           = 64;
    localparam int CFG_W           = 6;
    localparam int MAX_SEGMENTS_DEF = 63;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam logic [CFG_W-1:0] SEG_COUNT_RESET = CFG_W'(8);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CUBE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_WAIT  = 6'b001000,
        S_FINAL = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

endpackage

// File: rtl/cubic_bezier_forward_difference.sv
// Cubic Bezier point generator. Each accepted word carries four 3D control
// points (signed fixed point); the block emits n+1 curve points (n is
// segment_count, 0 taken as 1, capped at MAX_SEGMENTS), the final one flagged
// by last_point, using forward differencing in Q32.32 accumulators with
// saturated outputs. Setup runs nine 64-bit divisions on one shared
// bit-serial divider (load, quotient bits, write back), then the block
// emits one point per cycle while out_ready is high.
// in_ready is high only while idle, between curves; segment_count is written via cfg_we.
module cubic_bezier_forward_difference #(
    parameter int MAX_SEGMENTS = cbfd_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = cbfd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = cbfd_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [cbfd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] p0_x,
    input  logic signed [COORD_BITS-1:0] p0_y,
    input  logic signed [COORD_BITS-1:0] p0_z,
    input  logic signed [COORD_BITS-1:0] p1_x,
    input  logic signed [COORD_BITS-1:0] p1_y,
    input  logic signed [COORD_BITS-1:0] p1_z,
    input  logic signed [COORD_BITS-1:0] p2_x,
    input  logic signed [COORD_BITS-1:0] p2_y,
    input  logic signed [COORD_BITS-1:0] p2_z,
    input  logic signed [COORD_BITS-1:0] p3_x,
    input  logic signed [COORD_BITS-1:0] p3_y,
    input  logic signed [COORD_BITS-1:0] p3_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic                         last_point
);
    import cbfd_pkg::*;
    `include "cubic_bezier_forward_difference_defines.svh"

    localparam int ACC_EXT = 32 - FRAC_BITS;
    localparam int NB      = $clog2(MAX_SEGMENTS + 1);
    localparam int PW      = NB + 1;
    localparam int DEN_W   = 3 * NB;
    localparam int EXT_W   = ACC_W - COORD_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        (ACC_W'(1) << (COORD_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] seg_reg;
    logic [NB-1:0]    n_reg;
    logic [2*NB-1:0]  nsq_reg;
    logic [DEN_W-1:0] ncube_reg;
    logic [1:0]       axis_reg, term_reg;
    logic [PW-1:0]    pts_reg;

    logic [COORD_BITS-1:0] p0_reg [3];
    logic [COORD_BITS-1:0] p1_reg [3];
    logic [COORD_BITS-1:0] p2_reg [3];
    logic [COORD_BITS-1:0] p3_reg [3];
    logic [ACC_W-1:0] c1_reg [3];
    logic [ACC_W-1:0] c2_reg [3];
    logic [ACC_W-1:0] c3_reg [3];
    logic [ACC_W-1:0] pos_reg [3];
    logic [ACC_W-1:0] fd_reg [3];
    logic [ACC_W-1:0] sd_reg [3];
    logic [ACC_W-1:0] td_reg [3];

    logic [CFG_W-1:0] n_clip;
    logic signed [ACC_W-1:0] q0, q1, q2, q3, num, scaled;
    logic [ACC_W-1:0] mag, quot, coef;
    logic [DEN_W-1:0] den;
    div_stat_t        div_stat;
    logic             in_acc, out_acc, job_last;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = state_reg == S_EMIT;
    assign job_last = (axis_reg == 2'd2) && (term_reg == 2'd2);

    always_comb
    begin
        if (seg_reg == '0)
            n_clip = CFG_W'(1);
        else if (seg_reg > CFG_W'(MAX_SEGMENTS))
            n_clip = CFG_W'(MAX_SEGMENTS);
        else
            n_clip = seg_reg;
    end

    // numerator and divisor of the current division job, and its signed quotient
    always_comb
    begin
        q0 = {{EXT_W{p0_reg[axis_reg][COORD_BITS-1]}}, p0_reg[axis_reg]};
        q1 = {{EXT_W{p1_reg[axis_reg][COORD_BITS-1]}}, p1_reg[axis_reg]};
        q2 = {{EXT_W{p2_reg[axis_reg][COORD_BITS-1]}}, p2_reg[axis_reg]};
        q3 = {{EXT_W{p3_reg[axis_reg][COORD_BITS-1]}}, p3_reg[axis_reg]};
        unique case (term_reg)
            2'd0:
            begin
                num = ACC_W'(3 * (q1 - q0));
                den = DEN_W'(n_reg);
            end
            2'd1:
            begin
                num = ACC_W'(3 * (q0 - 2 * q1 + q2));
                den = DEN_W'(nsq_reg);
            end
            default:
            begin
                num = ACC_W'(q3 - q0 + 3 * (q1 - q2));
                den = ncube_reg;
            end
        endcase
        scaled = num <<< ACC_EXT;
        mag    = scaled[ACC_W-1] ? ACC_W'(-scaled) : scaled;
        coef   = scaled[ACC_W-1] ? ACC_W'(-quot) : quot;
    end

    cbfd_div #(
        .DEN_W(DEN_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == S_DIV),
        .dividend(mag),
        .divisor (den),
        .quotient(quot),
        .stat    (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_CUBE;
            S_CUBE:  state_next = S_DIV;
            S_DIV:   state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_stat.done)
                    state_next = job_last ? S_FINAL : S_DIV;
            end
            S_FINAL: state_next = S_EMIT;
            S_EMIT:  if (out_acc && pts_reg == PW'(1)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seg_reg   <= SEG_COUNT_RESET;
            axis_reg  <= '0;
            term_reg  <= '0;
            pts_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                seg_reg <= cfg_wdata;
            if (state_reg == S_CUBE)
            begin
                axis_reg <= '0;
                term_reg <= '0;
            end
            else if (state_reg == S_WAIT && div_stat.done)
            begin
                if (term_reg == 2'd2)
                begin
                    term_reg <= '0;
                    axis_reg <= axis_reg + 2'd1;
                end
                else
                    term_reg <= term_reg + 2'd1;
            end
            if (state_reg == S_FINAL)
                pts_reg <= PW'(n_reg) + PW'(1);
            else if (out_acc)
                pts_reg <= pts_reg - PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p0_reg[0] <= p0_x; p0_reg[1] <= p0_y; p0_reg[2] <= p0_z;
            p1_reg[0] <= p1_x; p1_reg[1] <= p1_y; p1_reg[2] <= p1_z;
            p2_reg[0] <= p2_x; p2_reg[1] <= p2_y; p2_reg[2] <= p2_z;
            p3_reg[0] <= p3_x; p3_reg[1] <= p3_y; p3_reg[2] <= p3_z;
            n_reg     <= NB'(n_clip);
            nsq_reg   <= (2*NB)'(n_clip) * (2*NB)'(n_clip);
        end
        if (state_reg == S_CUBE)
            ncube_reg <= DEN_W'(nsq_reg) * DEN_W'(n_reg);
        if (state_reg == S_WAIT && div_stat.done)
        begin
            unique case (term_reg)
                2'd0:    c1_reg[axis_reg] <= coef;
                2'd1:    c2_reg[axis_reg] <= coef;
                default: c3_reg[axis_reg] <= coef;
            endcase
        end
        for (int a = 0; a < 3; a++)
        begin
            if (state_reg == S_FINAL)
            begin
                pos_reg[a] <= {{EXT_W{p0_reg[a][COORD_BITS-1]}}, p0_reg[a]} << ACC_EXT;
                fd_reg[a]  <= c1_reg[a] + c2_reg[a] + c3_reg[a];
                sd_reg[a]  <= (c2_reg[a] << 1) + ACC_W'(6 * c3_reg[a]);
                td_reg[a]  <= ACC_W'(6 * c3_reg[a]);
            end
            else if (out_acc)
            begin
                pos_reg[a] <= pos_reg[a] + fd_reg[a];
                fd_reg[a]  <= fd_reg[a] + sd_reg[a];
                sd_reg[a]  <= sd_reg[a] + td_reg[a];
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] sat(input logic [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] v;
        v = $signed(acc) >>> ACC_EXT;
        if (v > SAT_HI)
            v = SAT_HI;
        else if (v < SAT_LO)
            v = SAT_LO;
        return v[COORD_BITS-1:0];
    endfunction

    assign out_x      = sat(pos_reg[0]);
    assign out_y      = sat(pos_reg[1]);
    assign out_z      = sat(pos_reg[2]);
    assign last_point = pts_reg == PW'(1);

    `CBFD_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "word accepted during emission")
    `CBFD_ASSERT_NEXT(a_setup_first, in_acc, !out_valid, "point before setup")
    `CBFD_ASSERT_NEXT(a_last_ends, out_acc && last_point, in_ready, "run did not end")
    `CBFD_ASSERT_IMP(a_div_only_setup, div_stat.busy, state_reg == S_WAIT, "divider busy outside setup")

endmodule

// File: rtl/cbfd_div.sv
module cbfd_div #(
    parameter int DEN_W = 18
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cbfd_pkg::ACC_W-1:0] dividend,
    input  logic [DEN_W-1:0]          divisor,
    output logic [cbfd_pkg::ACC_W-1:0] quotient,
    output cbfd_pkg::div_stat_t       stat
);
    import cbfd_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[ACC_W-1]};
        fits      = trial >= {1'b0, divisor};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[ACC_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
